// ===== hdl/in_place_counting_sort_desc_macros.svh =====
// Assertion macros for the in-place descending record sorter.
// Used by in_place_counting_sort_desc.sv; expects aclk and aresetn in scope.
`ifndef IN_PLACE_COUNTING_SORT_DESC_MACROS_SVH
`define IN_PLACE_COUNTING_SORT_DESC_MACROS_SVH

// checked only out of reset
`define IPCS_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// checked on every edge, reset included
`define IPCS_ASSERT_ALWAYS(name, prop, msg) \
    name: assert property (@(posedge aclk) prop) else $error(msg);

`endif

// ===== hdl/ipcs_pkg.sv =====
// Shared types and constants for the in-place descending record sorter.
// No dependencies.
`default_nettype none
package ipcs_pkg;

    localparam int DEPTH_DEF    = 1024;
    localparam int KEY_BITS_DEF = 8;
    localparam int TAG_BITS_DEF = 32;

    localparam int ACT_W   = 2;
    localparam int KEY_W   = 8;
    localparam int TAG_W   = 32;
    localparam int POS_W   = 10;
    localparam int COUNT_W = 11;
    localparam int STAT_W  = 2;
    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 56;

    localparam logic [ACT_W-1:0] ACT_LOAD = 2'd0;
    localparam logic [ACT_W-1:0] ACT_SORT = 2'd1;
    localparam logic [ACT_W-1:0] ACT_READ = 2'd2;
    localparam logic [ACT_W-1:0] ACT_NONE = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_RANGE = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RDOUT,
        ST_CLR,
        ST_HRD,
        ST_HKEY,
        ST_HBKT,
        ST_PRD,
        ST_PWR,
        ST_SRD,
        ST_SKEY,
        ST_SBKT,
        ST_SWP1,
        ST_SWP2
    } state_t;

endpackage
`default_nettype wire

// ===== hdl/in_place_counting_sort_desc.sv =====
// In-place descending counting sort over a record memory, with load and read.
// Depends on ipcs_pkg and in_place_counting_sort_desc_macros.svh.
//
//  channel | ports                    | tuser      | tdata (lowest bit up)
//  s_      | s_tvalid/s_tready        | action     | rec_key, rec_tag, position
//  m_      | m_tvalid/m_tready        | -          | out_key, out_tag, out_count, out_status
//
// Load: result registered on acceptance. Read: in range via a record memory read, out of range directly.
// Sort: clear of buckets 0..nb, histogram over the n records, prefix sum over the buckets,
// then the placement walk, nb the largest key loaded; every step goes through the record
// and bucket memories.
// Reset clears control, the record count and the largest key; memories are not cleared.
// A new transaction is taken only with the block idle and the result register free.
`default_nettype none
`include "in_place_counting_sort_desc_macros.svh"
module in_place_counting_sort_desc
    import ipcs_pkg::*;
#(
    parameter int DEPTH    = DEPTH_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF,
    parameter int TAG_BITS = TAG_BITS_DEF
) (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [S_DATA_W-1:0] s_tdata,  // rec_key[7:0], rec_tag[39:8], position[49:40]
    input  wire logic [ACT_W-1:0]    s_tuser,  // action[1:0]
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic [M_DATA_W-1:0]      m_tdata   // out_key, out_tag, out_count, out_status
);

    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW    = $clog2(DEPTH + 1);
    localparam int NBUCK = (1 << KEY_BITS) + 1;
    localparam int BW    = $clog2(NBUCK);
    localparam int RW    = KEY_BITS + TAG_BITS;
    localparam int WW    = 3 * CW;

    logic [RW-1:0] rec_mem [DEPTH];
    logic [WW-1:0] bkt_mem [NBUCK];

    logic          rec_we, rec_re, bkt_we, bkt_re;
    logic [AW-1:0] rec_waddr, rec_raddr;
    logic [RW-1:0] rec_wdata, rec_rdata;
    logic [BW-1:0] bkt_waddr, bkt_raddr;
    logic [WW-1:0] bkt_wdata, bkt_rdata;

    state_t        state_reg, state_next;
    logic [CW-1:0] count_reg, count_next;
    logic [KEY_BITS-1:0] maxk_reg, maxk_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [BW-1:0] bi_reg, bi_next;
    logic [CW-1:0] sum_reg, sum_next;
    logic [CW-1:0] bound_reg, bound_next;
    logic [RW-1:0] cur_reg, cur_next;
    logic [BW-1:0] h_reg, h_next;
    logic [AW-1:0] tgt_reg, tgt_next;
    logic          m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0] m_data_reg, m_data_next;

    logic                  accept;
    logic [KEY_W-1:0]      in_key;
    logic [TAG_W-1:0]      in_tag;
    logic [POS_W-1:0]      in_pos;
    logic [KEY_BITS+KEY_W-1:0] key_in_ext;
    logic [TAG_BITS+TAG_W-1:0] tag_in_ext;
    logic [CW+POS_W-1:0]   pos_ext, cnt_ext;
    logic [KEY_BITS-1:0]   key_in, rd_key;
    logic [TAG_BITS-1:0]   tag_in;
    logic [KEY_BITS+KEY_W-1:0] key_out_ext;
    logic [TAG_BITS+TAG_W-1:0] tag_out_ext;
    logic [CW+COUNT_W-1:0] cnt_out_ext;
    logic [KEY_BITS-1:0]   hk;
    logic [BW-1:0]         h_cur;
    logic [CW-1:0]         b_start, b_end, b_fill;
    logic [CW:0]           target;

    assign in_key = s_tdata[KEY_W-1:0];
    assign in_tag = s_tdata[KEY_W+TAG_W-1:KEY_W];
    assign in_pos = s_tdata[KEY_W+TAG_W+POS_W-1:KEY_W+TAG_W];
    assign key_in_ext = {{KEY_BITS{1'b0}}, in_key};
    assign tag_in_ext = {{TAG_BITS{1'b0}}, in_tag};
    assign key_in = key_in_ext[KEY_BITS-1:0];
    assign tag_in = tag_in_ext[TAG_BITS-1:0];
    assign pos_ext = {{CW{1'b0}}, in_pos};
    assign cnt_ext = {{POS_W{1'b0}}, count_reg};

    assign rd_key = rec_rdata[RW-1:TAG_BITS];
    assign key_out_ext = {{KEY_W{1'b0}}, rd_key};
    assign tag_out_ext = {{TAG_W{1'b0}}, rec_rdata[TAG_BITS-1:0]};
    assign b_start = bkt_rdata[WW-1:2*CW];
    assign b_end   = bkt_rdata[2*CW-1:CW];
    assign b_fill  = bkt_rdata[CW-1:0];
    assign target  = {1'b0, b_start} + {1'b0, b_fill};

    assign s_tready = (state_reg == ST_IDLE) && (!m_valid_reg || m_tready);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_comb begin
        hk = (state_reg == ST_SKEY || state_reg == ST_HKEY) ? rd_key : cur_reg[RW-1:TAG_BITS];
        if (hk <= maxk_reg) begin
            h_cur = {{(BW-KEY_BITS){1'b0}}, maxk_reg - hk};
        end else begin
            h_cur = '0;
        end
    end

    always_comb begin
        state_next   = state_reg;
        count_next   = count_reg;
        maxk_next    = maxk_reg;
        idx_next     = idx_reg;
        bi_next      = bi_reg;
        sum_next     = sum_reg;
        bound_next   = bound_reg;
        cur_next     = cur_reg;
        h_next       = h_reg;
        tgt_next     = tgt_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;
        rec_we = 1'b0; rec_waddr = '0; rec_wdata = '0;
        rec_re = 1'b0; rec_raddr = '0;
        bkt_we = 1'b0; bkt_waddr = '0; bkt_wdata = '0;
        bkt_re = 1'b0; bkt_raddr = '0;
        cnt_out_ext = {{COUNT_W{1'b0}}, count_reg};

        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_tuser)
                        ACT_LOAD: begin
                            m_valid_next = 1'b1;
                            if (count_reg < CW'(DEPTH)) begin
                                rec_we    = 1'b1;
                                rec_waddr = count_reg[AW-1:0];
                                rec_wdata = {key_in, tag_in};
                                count_next = count_reg + 1'b1;
                                if (key_in > maxk_reg) begin
                                    maxk_next = key_in;
                                end
                                cnt_out_ext = {{COUNT_W{1'b0}}, count_next};
                                m_data_next = '0;
                                m_data_next[KEY_W+TAG_W+COUNT_W-1:KEY_W+TAG_W] =
                                    cnt_out_ext[COUNT_W-1:0];
                            end else begin
                                m_data_next = '0;
                                m_data_next[KEY_W+TAG_W+COUNT_W-1:KEY_W+TAG_W] =
                                    cnt_out_ext[COUNT_W-1:0];
                                m_data_next[KEY_W+TAG_W+COUNT_W+STAT_W-1:KEY_W+TAG_W+COUNT_W] =
                                    STAT_FULL;
                            end
                        end
                        ACT_SORT: begin
                            bi_next    = '0;
                            state_next = ST_CLR;
                        end
                        ACT_READ: begin
                            if (pos_ext < cnt_ext) begin
                                rec_re     = 1'b1;
                                rec_raddr  = pos_ext[AW-1:0];
                                state_next = ST_RDOUT;
                            end else begin
                                m_valid_next = 1'b1;
                                m_data_next = '0;
                                m_data_next[KEY_W+TAG_W+COUNT_W-1:KEY_W+TAG_W] =
                                    cnt_out_ext[COUNT_W-1:0];
                                m_data_next[KEY_W+TAG_W+COUNT_W+STAT_W-1:KEY_W+TAG_W+COUNT_W] =
                                    STAT_RANGE;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RDOUT: begin
                m_valid_next = 1'b1;
                m_data_next = '0;
                m_data_next[KEY_W-1:0] = key_out_ext[KEY_W-1:0];
                m_data_next[KEY_W+TAG_W-1:KEY_W] = tag_out_ext[TAG_W-1:0];
                m_data_next[KEY_W+TAG_W+COUNT_W-1:KEY_W+TAG_W] = cnt_out_ext[COUNT_W-1:0];
                state_next = ST_IDLE;
            end
            ST_CLR: begin
                bkt_we    = 1'b1;
                bkt_waddr = bi_reg;
                bkt_wdata = '0;
                bi_next   = bi_reg + 1'b1;
                if (bi_reg == {{(BW-KEY_BITS){1'b0}}, maxk_reg}) begin
                    idx_next   = '0;
                    state_next = ST_HRD;
                end
            end
            ST_HRD: begin
                if (idx_reg < count_reg) begin
                    rec_re     = 1'b1;
                    rec_raddr  = idx_reg[AW-1:0];
                    state_next = ST_HKEY;
                end else begin
                    bi_next    = '0;
                    sum_next   = '0;
                    state_next = ST_PRD;
                end
            end
            ST_HKEY: begin
                h_next     = h_cur;
                bkt_re     = 1'b1;
                bkt_raddr  = h_cur;
                state_next = ST_HBKT;
            end
            ST_HBKT: begin
                bkt_we    = 1'b1;
                bkt_waddr = h_reg;
                bkt_wdata = {b_start, b_end + 1'b1, b_fill};
                idx_next  = idx_reg + 1'b1;
                state_next = ST_HRD;
            end
            ST_PRD: begin
                bkt_re     = 1'b1;
                bkt_raddr  = bi_reg;
                state_next = ST_PWR;
            end
            ST_PWR: begin
                bkt_we    = 1'b1;
                bkt_waddr = bi_reg;
                bkt_wdata = {sum_reg, sum_reg + b_end, {CW{1'b0}}};
                sum_next  = sum_reg + b_end;
                bi_next   = bi_reg + 1'b1;
                if (bi_reg == {{(BW-KEY_BITS){1'b0}}, maxk_reg}) begin
                    bound_next = sum_reg;
                    idx_next   = '0;
                    state_next = ST_SRD;
                end else begin
                    state_next = ST_PRD;
                end
            end
            ST_SRD: begin
                if (idx_reg < bound_reg && idx_reg < count_reg) begin
                    rec_re     = 1'b1;
                    rec_raddr  = idx_reg[AW-1:0];
                    state_next = ST_SKEY;
                end else begin
                    m_valid_next = 1'b1;
                    m_data_next = '0;
                    m_data_next[KEY_W+TAG_W+COUNT_W-1:KEY_W+TAG_W] = cnt_out_ext[COUNT_W-1:0];
                    state_next = ST_IDLE;
                end
            end
            ST_SKEY: begin
                cur_next   = rec_rdata;
                h_next     = h_cur;
                bkt_re     = 1'b1;
                bkt_raddr  = h_cur;
                state_next = ST_SBKT;
            end
            ST_SBKT: begin
                bkt_we    = 1'b1;
                bkt_waddr = h_reg;
                bkt_wdata = {b_start, b_end, b_fill + 1'b1};
                if (h_reg < {{(BW-KEY_BITS){1'b0}}, maxk_reg} && idx_reg >= b_start
                        && idx_reg < b_end) begin
                    idx_next   = idx_reg + 1'b1;
                    state_next = ST_SRD;
                end else if (target >= {1'b0, count_reg}) begin
                    m_valid_next = 1'b1;
                    m_data_next = '0;
                    m_data_next[KEY_W+TAG_W+COUNT_W-1:KEY_W+TAG_W] = cnt_out_ext[COUNT_W-1:0];
                    state_next = ST_IDLE;
                end else begin
                    tgt_next   = target[AW-1:0];
                    rec_re     = 1'b1;
                    rec_raddr  = target[AW-1:0];
                    state_next = ST_SWP1;
                end
            end
            ST_SWP1: begin
                rec_we     = 1'b1;
                rec_waddr  = idx_reg[AW-1:0];
                rec_wdata  = rec_rdata;
                state_next = ST_SWP2;
            end
            ST_SWP2: begin
                rec_we     = 1'b1;
                rec_waddr  = tgt_reg;
                rec_wdata  = cur_reg;
                state_next = ST_SRD;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (rec_we) begin
            rec_mem[rec_waddr] <= rec_wdata;
        end
        if (rec_re) begin
            rec_rdata <= rec_mem[rec_raddr];
        end
        if (bkt_we) begin
            bkt_mem[bkt_waddr] <= bkt_wdata;
        end
        if (bkt_re) begin
            bkt_rdata <= bkt_mem[bkt_raddr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            maxk_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            maxk_reg    <= maxk_next;
            m_valid_reg <= m_valid_next;
        end
        idx_reg    <= idx_next;
        bi_reg     <= bi_next;
        sum_reg    <= sum_next;
        bound_reg  <= bound_next;
        cur_reg    <= cur_next;
        h_reg      <= h_next;
        tgt_reg    <= tgt_next;
        m_data_reg <= m_data_next;
    end

    `IPCS_ASSERT(a_count_in_range, count_reg <= CW'(DEPTH), "record count above capacity")
    `IPCS_ASSERT(a_count_held_in_sort, state_reg != ST_IDLE |=> $stable(count_reg), "count moved")
    `IPCS_ASSERT(a_walk_bounded, state_reg == ST_SRD |-> idx_reg <= count_reg, "walk past records")
    `IPCS_ASSERT_ALWAYS(a_reset_clears, !aresetn |=> count_reg == '0 && !m_tvalid, "reset failed")

endmodule
`default_nettype wire
